// File: hdl/signed_integer_to_radix_symbols_top_assert.svh
// assertion macros shared by the radix symbol block
// no dependencies, included by the rtl files that check themselves
`ifndef SIGNED_INTEGER_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH
`define SIGNED_INTEGER_TO_RADIX_SYMBOLS_TOP_ASSERT_SVH

// same-cycle implication, checking stops while reset is high
`define SIRS_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sirs: implication check failed");

// next-cycle implication
`define SIRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sirs: next-cycle check failed");

`endif

// File: hdl/sirs_pkg.sv
// shared constants, types and tables of the radix symbol block
// no dependencies, compiled first
`timescale 1ns / 1ps
`default_nettype none

package sirs_pkg;

   localparam int SIRS_MAX_BASE    = 16;
   localparam int SIRS_SYM_STORE   = 16;
   localparam int SIRS_NUMBER_W    = 32;
   localparam int SIRS_SYMBOL_W    = 8;
   localparam int SIRS_ALEN_W      = 5;
   localparam int SIRS_DIGIT_DEPTH = 32;
   localparam int SIRS_CSR_INDEX_W = 2;
   localparam int SIRS_CSR_DATA_W  = 64;

   // register indexes
   localparam logic [SIRS_CSR_INDEX_W-1:0] SIRS_CSR_ALPHABET_LENGTH = 2'd0;
   localparam logic [SIRS_CSR_INDEX_W-1:0] SIRS_CSR_SYMBOLS_LOW     = 2'd1;
   localparam logic [SIRS_CSR_INDEX_W-1:0] SIRS_CSR_SYMBOLS_HIGH    = 2'd2;

   localparam logic [SIRS_SYMBOL_W-1:0] SIRS_CH_MINUS = 8'h2D;
   localparam logic [SIRS_SYMBOL_W-1:0] SIRS_CH_PLUS  = 8'h2B;

   typedef logic [SIRS_SYM_STORE-1:0][SIRS_SYMBOL_W-1:0] sirs_alphabet_type;

   // floor(2^32 / r); quotient estimate is exact or one low
   localparam logic [31:0] SIRS_RECIP [0:31] = '{
      32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 32'h5555_5555,
      32'h4000_0000, 32'h3333_3333, 32'h2AAA_AAAA, 32'h2492_4924,
      32'h2000_0000, 32'h1C71_C71C, 32'h1999_9999, 32'h1745_D174,
      32'h1555_5555, 32'h13B1_3B13, 32'h1249_2492, 32'h1111_1111,
      32'h1000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
      32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000
   };

endpackage

`default_nettype wire

// File: hdl/sirs_if.sv
// request and response channel interfaces of the radix symbol block
// depends on sirs_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sirs_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [sirs_pkg::SIRS_NUMBER_W-1:0] number;

   modport source (output valid, output number, input ready);
   modport sink   (input valid, input number, output ready);
endinterface

interface sirs_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [sirs_pkg::SIRS_SYMBOL_W-1:0] symbol;
   logic                               last;

   modport source (output valid, output symbol, output last, input ready);
   modport sink   (input valid, input symbol, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/sirs_alphabet.sv
// configuration registers and alphabet check, gives the registered radix
// depends on sirs_pkg
`timescale 1ns / 1ps
`default_nettype none

module sirs_alphabet #(
   parameter int MAX_BASE = sirs_pkg::SIRS_MAX_BASE
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [sirs_pkg::SIRS_CSR_INDEX_W-1:0]  csr_index,
   input  logic [sirs_pkg::SIRS_CSR_DATA_W-1:0]   csr_wdata,
   output logic [$clog2(MAX_BASE+1)-1:0]          radix,
   output sirs_pkg::sirs_alphabet_type            alphabet
);

   localparam int RW = $clog2(MAX_BASE + 1);
   localparam int LW = sirs_pkg::SIRS_ALEN_W;
   localparam int NS = sirs_pkg::SIRS_SYM_STORE;
   localparam int CW = $clog2(NS + 1);

   logic [LW-1:0]                          alen_ff;
   logic [sirs_pkg::SIRS_CSR_DATA_W-1:0]   sym_lo_ff;
   logic [sirs_pkg::SIRS_CSR_DATA_W-1:0]   sym_hi_ff;
   logic [RW-1:0]                          radix_ff;
   logic [RW-1:0]                          radix_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         alen_ff   <= '0;
         sym_lo_ff <= '0;
         sym_hi_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            sirs_pkg::SIRS_CSR_ALPHABET_LENGTH: alen_ff <= csr_wdata[LW-1:0];
            sirs_pkg::SIRS_CSR_SYMBOLS_LOW:     sym_lo_ff <= csr_wdata;
            sirs_pkg::SIRS_CSR_SYMBOLS_HIGH:    sym_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign alphabet = {sym_hi_ff, sym_lo_ff};

   // effective alphabet: prefix of nonzero bytes below the clamped length
   always_comb begin
      logic [LW-1:0] lim;
      logic [NS-1:0] active;
      logic          run;
      logic          bad;
      logic [CW-1:0] n;
      lim = (alen_ff > LW'(MAX_BASE)) ? LW'(MAX_BASE) : alen_ff;
      run = 1'b1;
      bad = 1'b0;
      for (int i = 0; i < NS; i++) begin
         run       = run && (LW'(i) < lim) && (alphabet[i] != '0);
         active[i] = run;
      end
      n = CW'($countones(active));
      for (int i = 0; i < NS; i++) begin
         if (active[i] && (alphabet[i] == sirs_pkg::SIRS_CH_MINUS ||
                           alphabet[i] == sirs_pkg::SIRS_CH_PLUS)) begin
            bad = 1'b1;
         end
         for (int j = i + 1; j < NS; j++) begin
            if (active[j] && alphabet[i] == alphabet[j]) begin
               bad = 1'b1;
            end
         end
      end
      radix_in = (n < CW'(2) || bad) ? '0 : RW'(n);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff <= '0;
      end else begin
         radix_ff <= radix_in;
      end
   end

   assign radix = radix_ff;

endmodule

`default_nettype wire

// File: hdl/signed_integer_to_radix_symbols_top.sv
// Signed integer to radix symbols. Each request word carries a signed
// 32-bit number; the block answers with one response word per symbol,
// most significant digit first, a '-' in front of negative numbers and
// last set on the final symbol. The radix is the size of the configured
// alphabet (registers alphabet_length, symbols_low, symbols_high at csr
// indexes 0, 1 and 2); when the alphabet is invalid the number is taken
// and nothing comes out. Steps: the number is sampled, the registered
// radix is checked, then each digit passes the MUL and DIV states of one
// shared reciprocal multiplier with a correction step (a 32x32 product,
// then a small multiply, subtract and compare), then the symbols are
// loaded into the output register while the response side takes words.
// A number has up to 10 digits for radix 10 and up to 32 digits for
// radix 2. The last symbol sits in an output register, so the
// next request is taken in the cycle after it is loaded.
// depends on sirs_pkg, sirs_if, sirs_alphabet and the assertion header
`timescale 1ns / 1ps
`default_nettype none

`include "signed_integer_to_radix_symbols_top_assert.svh"

module signed_integer_to_radix_symbols_top #(
   parameter int MAX_BASE = sirs_pkg::SIRS_MAX_BASE
) (
   input  logic                                   clock,
   input  logic                                   reset,
   sirs_req_if.sink                               req_if,
   sirs_rsp_if.source                             rsp_if,
   input  logic                                   csr_we,
   input  logic [sirs_pkg::SIRS_CSR_INDEX_W-1:0]  csr_index,
   input  logic [sirs_pkg::SIRS_CSR_DATA_W-1:0]   csr_wdata
);

   localparam int RW    = $clog2(MAX_BASE + 1);
   localparam int DW    = $clog2(MAX_BASE);
   localparam int NW    = sirs_pkg::SIRS_NUMBER_W;
   localparam int DEPTH = sirs_pkg::SIRS_DIGIT_DEPTH;
   localparam int AW    = $clog2(DEPTH);

   // sequencer states
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_CHECK = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_SIGN  = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [RW-1:0]                  radix;
   sirs_pkg::sirs_alphabet_type    alphabet;

   sirs_alphabet #(
      .MAX_BASE (MAX_BASE)
   ) u_alphabet (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .radix     (radix),
      .alphabet  (alphabet)
   );

   logic [2:0]                     state_ff, state_in;
   logic [NW-1:0]                  mag_ff, mag_in;
   logic                           neg_ff, neg_in;
   logic [AW-1:0]                  cnt_ff, cnt_in;
   logic [2*NW-1:0]                prod_ff, prod_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sirs_pkg::SIRS_SYMBOL_W-1:0] rsp_symbol_ff;
   logic                           rsp_last_ff;
   logic [DW-1:0]                  digit_mem [DEPTH];

   logic                           out_free;
   logic                           load_sign;
   logic                           load_digit;
   logic                           digit_we;
   logic [DW-1:0]                  digit;
   logic [NW-1:0]                  quot;
   logic                           div_done;
   logic [NW-1:0]                  req_bits;

   assign req_bits  = NW'(unsigned'(req_if.number));
   assign out_free  = !rsp_valid_ff || rsp_if.ready;
   assign load_sign  = (state_ff == ST_SIGN) && out_free;
   assign load_digit = (state_ff == ST_EMIT) && out_free;
   assign digit_we   = (state_ff == ST_DIV);

   // shared divide unit: reciprocal product, then one correction step
   always_comb begin
      logic [NW-1:0] q_est;
      logic [NW-1:0] qr;
      logic [NW-1:0] rem;
      logic          ge;
      q_est = prod_ff[2*NW-1:NW];
      qr    = q_est * NW'(radix);
      rem   = mag_ff - qr;
      ge    = rem >= NW'(radix);
      quot  = ge ? q_est + NW'(1) : q_est;
      digit = ge ? DW'(rem - NW'(radix)) : DW'(rem);
      prod_in = (2*NW)'(mag_ff) * (2*NW)'(sirs_pkg::SIRS_RECIP[5'(radix)]);
   end

   assign div_done = (quot == '0) || (cnt_ff == AW'(DEPTH - 1));

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               neg_in   = req_bits[NW-1];
               mag_in   = req_bits[NW-1] ? NW'(0) - req_bits : req_bits;
               cnt_in   = '0;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = (radix == '0) ? ST_IDLE : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            mag_in = quot;
            if (div_done) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end else begin
               cnt_in   = cnt_ff + AW'(1);
               state_in = ST_MUL;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               if (cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  cnt_in = cnt_ff - AW'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (load_sign || load_digit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      prod_ff <= prod_in;
   end

   // digit stack, filled least significant first and read back downward
   always_ff @(posedge clock) begin
      if (digit_we) begin
         digit_mem[cnt_ff] <= digit;
      end
      if (load_sign) begin
         rsp_symbol_ff <= sirs_pkg::SIRS_CH_MINUS;
         rsp_last_ff   <= 1'b0;
      end else if (load_digit) begin
         rsp_symbol_ff <= alphabet[digit_mem[cnt_ff]];
         rsp_last_ff   <= (cnt_ff == '0);
      end
   end

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.symbol = rsp_symbol_ff;
   assign rsp_if.last   = rsp_last_ff;

   `SIRS_ASSERT_IMPLIES(a_digit_below_radix, clock, reset, state_ff == ST_DIV, RW'(digit) < radix)
   `SIRS_ASSERT_NEXT(a_quotient_shrinks, clock, reset, state_ff == ST_DIV && !div_done, mag_ff < $past(mag_ff))
   `SIRS_ASSERT_NEXT(a_bad_alphabet_drops, clock, reset, state_ff == ST_CHECK && radix == '0, state_ff == ST_IDLE)
   `SIRS_ASSERT_NEXT(a_final_symbol_last, clock, reset, load_digit && cnt_ff == '0, state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff)
   `SIRS_ASSERT_IMPLIES(a_radix_sane, clock, reset, 1'b1, radix != RW'(1) && radix <= RW'(MAX_BASE))

endmodule

`default_nettype wire
